[hdl/bpf_pkg.sv]
`default_nettype none
package bpf_pkg;

	localparam int SIDE   = 16;
	localparam int ROW_W  = $clog2(SIDE);
	localparam int POS_W  = 2 * ROW_W;
	localparam int CELLS  = SIDE * SIDE;
	localparam int BYTE_W = 8;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [ROW_W-1:0]  coord_t;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ENC  = 2'd1,
		OP_DEC  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// access bundle for the key square memory
	typedef struct packed {
		logic  wr;
		pos_t  wr_addr;
		byte_t wr_data;
		logic  rd;
		pos_t  rd_addr_a;
		pos_t  rd_addr_b;
	} sq_req_t;

endpackage
`default_nettype wire

[hdl/bpf_locate.sv]
`default_nettype none
module bpf_locate
	import bpf_pkg::*;
(
	input  wire   clk,
	input  wire   wr_en,
	input  byte_t wr_value,
	input  pos_t  wr_pos,
	input  wire   rd_en,
	input  byte_t rd_value_a,
	input  byte_t rd_value_b,
	output pos_t  pos_a_s1,
	output pos_t  pos_b_s1
);

	// cell of each byte value, one entry per value
	pos_t pos_mem [CELLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[wr_value] <= wr_pos;
		end
		if (rd_en) begin
			pos_a_s1 <= pos_mem[rd_value_a];
			pos_b_s1 <= pos_mem[rd_value_b];
		end
	end

endmodule
`default_nettype wire

[hdl/bpf_lane.sv]
`default_nettype none
module bpf_lane
	import bpf_pkg::*;
(
	input  pos_t own_pos,
	input  pos_t oth_pos,
	input  wire  decipher,
	output pos_t cell_addr
);

	coord_t own_row, own_col, oth_row, oth_col, step;

	always_comb begin
		own_row = own_pos[POS_W-1:ROW_W];
		own_col = own_pos[ROW_W-1:0];
		oth_row = oth_pos[POS_W-1:ROW_W];
		oth_col = oth_pos[ROW_W-1:0];
		// one less than SIDE steps back with wrap
		step    = decipher ? coord_t'(SIDE - 1) : coord_t'(1);
		if (own_row == oth_row) begin
			cell_addr = {own_row, coord_t'(own_col + step)};
		end else if (own_col == oth_col) begin
			cell_addr = {coord_t'(own_row + step), own_col};
		end else begin
			cell_addr = {oth_row, own_col};
		end
	end

endmodule
`default_nettype wire

[hdl/bpf_square.sv]
`default_nettype none
module bpf_square
	import bpf_pkg::*;
(
	input  wire     clk,
	input  sq_req_t req,
	output byte_t   cell_a_s2,
	output byte_t   cell_b_s2
);

	byte_t sq_mem [CELLS];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			sq_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd) begin
			cell_a_s2 <= sq_mem[req.rd_addr_a];
			cell_b_s2 <= sq_mem[req.rd_addr_b];
		end
	end

endmodule
`default_nettype wire

[hdl/byte_playfair_digraph_cipher_unit.sv]
// Byte Playfair digraph cipher over a 16x16 square of all 256 byte values.
// Input channel (in_valid/in_ready): one beat per item. A load beat writes
// one square cell and the matching reverse position entry; an encipher or
// decipher beat carries a byte pair and yields one output beat (out_a,
// out_b). Unused opcode beats are taken and dropped. Load the full square
// before sending pairs; cells never loaded read back as garbage.
// Throughput: one beat per cycle while the receiver keeps up, loads and
// pairs mixed in any order. A pair goes through stage 1, which reads byte
// positions, then stage 2, which reads the square cells through two lane
// address units; then the merge mux picks lookup or pass-through.
// Stall: the two stages advance independently, so a new beat is still
// taken while a result waits in stage 2, as long as stage 1 is free.
// Square writes happen in stage 2, in beat order with the lookups.
// Reset clears only the stage valid flags; both memories keep their
// contents and no clearing pass runs.
`default_nettype none
module byte_playfair_digraph_cipher_unit
	import bpf_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  opcode,
	input  wire  [7:0]  byte_a,
	input  wire  [7:0]  byte_b,
	input  wire         pad_second,
	input  wire  [7:0]  cell_position,
	input  wire  [7:0]  cell_value,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_a,
	output logic [7:0]  out_b
);

	op_t     op_in;
	byte_t   b_in;
	logic    accept, acc_load, acc_pair;
	logic    adv_s1, adv_s2;

	// stage 1
	logic    valid_s1, load_s1, dec_s1;
	byte_t   a_s1, b_s1, val_s1;
	pos_t    cpos_s1, pos_a_s1, pos_b_s1, addr_a, addr_b;

	// stage 2
	logic    valid_s2, same_s2;
	byte_t   a_s2, b_s2, cell_a_s2, cell_b_s2;
	sq_req_t sq_req;

	always_comb begin
		op_in    = op_t'(opcode);
		// a padded tail uses zero as its second byte
		b_in     = pad_second ? '0 : byte_t'(byte_b);
		// stage 2 frees when its result leaves; stage 1 when it moves on
		adv_s2   = !valid_s2 || out_ready;
		adv_s1   = !valid_s1 || adv_s2;
		in_ready = adv_s1;
		accept   = in_valid && in_ready;
		acc_load = accept && (op_in == OP_LOAD);
		acc_pair = accept && (op_in == OP_ENC || op_in == OP_DEC);
	end

	// reverse lookup: byte value -> cell, written on load at acceptance
	bpf_locate u_locate (
		.clk        (clk),
		.wr_en      (acc_load),
		.wr_value   (cell_value),
		.wr_pos     (cell_position),
		.rd_en      (acc_pair),
		.rd_value_a (byte_a),
		.rd_value_b (b_in),
		.pos_a_s1   (pos_a_s1),
		.pos_b_s1   (pos_b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= acc_load || acc_pair;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			load_s1 <= (op_in == OP_LOAD);
			dec_s1  <= (op_in == OP_DEC);
			a_s1    <= byte_a;
			b_s1    <= b_in;
			cpos_s1 <= cell_position;
			val_s1  <= cell_value;
		end
	end

	// one lane per byte of the pair; each finds its own square cell
	bpf_lane u_lane_a (
		.own_pos   (pos_a_s1),
		.oth_pos   (pos_b_s1),
		.decipher  (dec_s1),
		.cell_addr (addr_a)
	);

	bpf_lane u_lane_b (
		.own_pos   (pos_b_s1),
		.oth_pos   (pos_a_s1),
		.decipher  (dec_s1),
		.cell_addr (addr_b)
	);

	always_comb begin
		sq_req.wr        = adv_s2 && valid_s1 && load_s1;
		sq_req.wr_addr   = cpos_s1;
		sq_req.wr_data   = val_s1;
		sq_req.rd        = adv_s2 && valid_s1 && !load_s1;
		sq_req.rd_addr_a = addr_a;
		sq_req.rd_addr_b = addr_b;
	end

	bpf_square u_square (
		.clk       (clk),
		.req       (sq_req),
		.cell_a_s2 (cell_a_s2),
		.cell_b_s2 (cell_b_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			// loads finish here and produce no beat
			valid_s2 <= valid_s1 && !load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (sq_req.rd) begin
			same_s2 <= (pos_a_s1 == pos_b_s1);
			a_s2    <= a_s1;
			b_s2    <= b_s1;
		end
	end

	// merge: a pair in one cell passes unchanged, else take the lane lookups
	always_comb begin
		out_valid = valid_s2;
		out_a     = same_s2 ? a_s2 : cell_a_s2;
		out_b     = same_s2 ? b_s2 : cell_b_s2;
	end

endmodule
`default_nettype wire

[hdl/bpf_checker.sv]
`default_nettype none
module bpf_checker
	import bpf_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_ready,
	input wire [1:0] opcode,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_a,
	input wire [7:0] out_b
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b))
		else $error("output beat dropped or changed while stalled");

	// with the output stage empty, the input side never stalls
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// a beat taken during an output stall fills stage 1; a continued stall blocks
	a_fill_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready &&
		opcode != OP_NONE ##1 out_valid && !out_ready |-> !in_ready)
		else $error("input taken with both stages full");

	// no beat without a pair earlier in the pipe
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (opcode == OP_ENC ||
		opcode == OP_DEC), 2) || $past(!in_ready, 1) || $past(!in_ready, 2))
		else $error("output beat without a pair");

endmodule

bind byte_playfair_digraph_cipher_unit bpf_checker u_bpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.opcode    (opcode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_a     (out_a),
	.out_b     (out_b)
);
`default_nettype wire

[sim/tb_byte_playfair_digraph_cipher_unit.sv]
`default_nettype none
module tb_byte_playfair_digraph_cipher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import bpf_pkg::*;

	// one input beat as the driver presents it
	typedef struct {
		op_t   op;
		byte_t a;
		byte_t b;
		logic  pad;
		pos_t  cpos;
		byte_t val;
		logic  hold;   // hold this beat back until no result is outstanding
	} beat_t;

	// one output beat: the transformed byte pair
	typedef struct {
		byte_t a;
		byte_t b;
	} byte_pair_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic [1:0]  opcode        = '0;
	logic [7:0]  byte_a        = '0;
	logic [7:0]  byte_b        = '0;
	logic        pad_second    = 1'b0;
	logic [7:0]  cell_position = '0;
	logic [7:0]  cell_value    = '0;
	logic        out_ready     = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [7:0]  out_a;
	logic [7:0]  out_b;

	// beats waiting for the driver, filled by the stimulus block
	beat_t       pending [$];
	// cipher outputs predicted for accepted pairs, oldest first
	byte_pair_t  cipher_due [$];

	// predictor copy of the block's memories, updated in beat order
	byte_t       key_cells [CELLS];
	pos_t        cell_of   [CELLS];
	// stimulus-side view of the square, used to aim pairs at rows and columns
	byte_t       plan_sq   [CELLS];

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          errors         = 0;

	byte_playfair_digraph_cipher_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.byte_a        (byte_a),
		.byte_b        (byte_b),
		.pad_second    (pad_second),
		.cell_position (cell_position),
		.cell_value    (cell_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_a         (out_a),
		.out_b         (out_b)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// give up if the run hangs
	initial begin
		#3600000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	// Apply one accepted beat to the predictor. Loads write the square and the
	// reverse entry; pairs queue the expected output; unused opcodes do nothing.
	task automatic cipher_beat(input op_t op, input byte_t a, input byte_t b_raw,
			input logic pad, input pos_t cpos, input byte_t val);
		byte_t      b;
		pos_t       pa;
		pos_t       pb;
		coord_t     ra;
		coord_t     ca;
		coord_t     rb;
		coord_t     cb;
		coord_t     stp;
		byte_pair_t res;
		b = pad ? byte_t'(0) : b_raw;
		case (op)
			OP_LOAD: begin
				key_cells[cpos] = val;
				cell_of[val]    = cpos;
			end
			OP_ENC, OP_DEC: begin
				// one step forward to encipher, one back (mod SIDE) to decipher
				stp = (op == OP_ENC) ? coord_t'(1) : coord_t'(SIDE - 1);
				pa  = cell_of[a];
				pb  = cell_of[b];
				{ra, ca} = pa;
				{rb, cb} = pb;
				if (pa == pb) begin
					res.a = a;
					res.b = b;
				end else if (ra == rb) begin
					res.a = key_cells[{ra, coord_t'(ca + stp)}];
					res.b = key_cells[{rb, coord_t'(cb + stp)}];
				end else if (ca == cb) begin
					res.a = key_cells[{coord_t'(ra + stp), ca}];
					res.b = key_cells[{coord_t'(rb + stp), cb}];
				end else begin
					res.a = key_cells[{rb, ca}];
					res.b = key_cells[{ra, cb}];
				end
				cipher_due.push_back(res);
			end
			default: ;
		endcase
	endtask

	// queue helpers: fields the opcode ignores carry random junk
	task automatic queue_load(input pos_t p, input byte_t v);
		beat_t it;
		it.op   = OP_LOAD;
		it.a    = byte_t'($urandom);
		it.b    = byte_t'($urandom);
		it.pad  = 1'($urandom);
		it.cpos = p;
		it.val  = v;
		it.hold = 1'b0;
		plan_sq[p] = v;
		pending.push_back(it);
	endtask

	task automatic queue_pair(input op_t op, input byte_t a, input byte_t b, input logic pad);
		beat_t it;
		it.op   = op;
		it.a    = a;
		it.b    = b;
		it.pad  = pad;
		it.cpos = pos_t'($urandom);
		it.val  = byte_t'($urandom);
		it.hold = 1'b0;
		pending.push_back(it);
	endtask

	task automatic queue_unused_op();
		beat_t it;
		it.op   = OP_NONE;
		it.a    = byte_t'($urandom);
		it.b    = byte_t'($urandom);
		it.pad  = 1'($urandom);
		it.cpos = pos_t'($urandom);
		it.val  = byte_t'($urandom);
		it.hold = 1'b0;
		pending.push_back(it);
	endtask

	// Driver: present the next pending beat once the line is free. Hold valid
	// and payload steady until the beat is taken; idle at random between beats.
	always @(posedge clk or negedge arst_n) begin
		beat_t nxt;
		logic  go;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			go = (pending.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
			// a held beat waits for an empty line and no outstanding result
			if (go && pending[0].hold && (in_valid || cipher_due.size() != 0))
				go = 1'b0;
			if (go) begin
				nxt = pending.pop_front();
				opcode        <= nxt.op;
				byte_a        <= nxt.a;
				byte_b        <= nxt.b;
				pad_second    <= nxt.pad;
				cell_position <= nxt.cpos;
				cell_value    <= nxt.val;
				in_valid      <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: predict on every accepted input beat, then check every
	// accepted output beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		byte_pair_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (in_valid && in_ready)
				cipher_beat(op_t'(opcode), byte_a, byte_b, pad_second, cell_position,
					cell_value);
			if (out_valid && out_ready) begin
				if (cipher_due.size() == 0) begin
					report_mismatch("output beat with nothing expected",
						int'({out_a, out_b}), 0);
				end else begin
					want = cipher_due.pop_front();
					if (out_a !== want.a)
						report_mismatch("out_a", int'(out_a), int'(want.a));
					if (out_b !== want.b)
						report_mismatch("out_b", int'(out_b), int'(want.b));
				end
			end
		end
	end

	// Stimulus: load a full random square, run the directed pairs, then four
	// random phases with different idle and stall rates.
	initial begin
		byte_t  perm [CELLS];
		byte_t  t;
		byte_t  dup;
		byte_t  ba;
		byte_t  bb;
		pos_t   p;
		pos_t   q;
		coord_t r;
		coord_t c1;
		coord_t c2;
		int     i;
		int     j;
		int     ph;
		int     k;
		int     shape;
		int     idle_of  [4] = '{0, 73, 0, 16};
		int     stall_of [4] = '{0, 0, 73, 16};

		// hold reset, then release it away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every cell and every reverse entry gets written before any lookup
		for (i = 0; i < CELLS; i++)
			perm[i] = byte_t'(i);
		for (i = CELLS - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			t       = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (i = 0; i < CELLS; i++)
			queue_load(pos_t'(i), perm[i]);

		// same row: right wrap on encipher, left wrap on decipher
		queue_pair(OP_ENC, plan_sq[8'h3F], plan_sq[8'h30], 1'b0);
		queue_pair(OP_DEC, plan_sq[8'h30], plan_sq[8'h3F], 1'b0);
		// same column: down wrap on encipher, up wrap on decipher
		queue_pair(OP_ENC, plan_sq[8'hF7], plan_sq[8'h27], 1'b0);
		queue_pair(OP_DEC, plan_sq[8'h07], plan_sq[8'hF7], 1'b0);
		// rectangle corners
		queue_pair(OP_ENC, plan_sq[8'h00], plan_sq[8'hFF], 1'b0);
		queue_pair(OP_DEC, plan_sq[8'hF0], plan_sq[8'h0F], 1'b0);
		// same byte twice passes unchanged
		queue_pair(OP_ENC, 8'hFF, 8'hFF, 1'b0);
		queue_pair(OP_DEC, 8'h00, 8'h00, 1'b0);
		// padded tail: second byte forced to zero, zero pair passes through
		queue_pair(OP_ENC, 8'h00, 8'hFF, 1'b1);
		queue_pair(OP_DEC, 8'hFF, 8'hA5, 1'b1);
		queue_pair(OP_ENC, 8'h00, 8'hFF, 1'b0);
		queue_pair(OP_DEC, 8'hFF, 8'h00, 1'b0);
		// unused opcode is dropped
		queue_unused_op();
		queue_unused_op();
		// broken square: duplicate a byte, leave a stale position, then repair
		t   = plan_sq[8'h00];
		dup = plan_sq[8'hFF];
		queue_load(8'h00, dup);
		queue_pair(OP_ENC, t, dup, 1'b0);
		queue_pair(OP_DEC, dup, plan_sq[8'h55], 1'b0);
		queue_load(8'h00, t);
		queue_load(8'hFF, dup);
		// swap two cells and use them right away
		t = plan_sq[8'h12];
		queue_load(8'h12, plan_sq[8'h34]);
		queue_load(8'h34, t);
		queue_pair(OP_ENC, t, plan_sq[8'h12], 1'b0);

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_of[ph];
			recv_stall_pct = stall_of[ph];
			for (i = 0; i < 30; i++) begin
				k = $urandom_range(0, 99);
				if (k < 62) begin
					// pairs aimed at rows, columns and repeats more often than chance
					shape = $urandom_range(0, 9);
					r     = coord_t'($urandom);
					c1    = coord_t'($urandom);
					c2    = coord_t'($urandom);
					if (shape < 3) begin
						ba = plan_sq[{r, c1}];
						bb = plan_sq[{r, c2}];
					end else if (shape < 6) begin
						ba = plan_sq[{c1, r}];
						bb = plan_sq[{c2, r}];
					end else if (shape == 6) begin
						ba = byte_t'($urandom);
						bb = ba;
					end else begin
						ba = byte_t'($urandom);
						bb = byte_t'($urandom);
					end
					queue_pair($urandom_range(0, 1) ? OP_ENC : OP_DEC, ba, bb,
						$urandom_range(0, 99) < 12);
				end else if (k < 80) begin
					// swap keeps the square a permutation
					p = pos_t'($urandom);
					q = pos_t'($urandom);
					t = plan_sq[p];
					queue_load(p, plan_sq[q]);
					queue_load(q, t);
				end else if (k < 87) begin
					queue_load(pos_t'($urandom), byte_t'($urandom));
				end else if (k < 93) begin
					queue_unused_op();
				end else begin
					queue_pair($urandom_range(0, 1) ? OP_ENC : OP_DEC, byte_t'($urandom),
						byte_t'($urandom), 1'b1);
				end
			end
			// stall the sender until the output side has drained once
			if (ph == 2)
				pending[0].hold = 1'b1;
			while (pending.size() != 0)
				@(negedge clk);
		end

		// wait for the last beat to go in and every result to come out
		while (in_valid)
			@(negedge clk);
		for (i = 0; i < 5000 && cipher_due.size() != 0; i++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (cipher_due.size() != 0)
			report_mismatch("results never delivered", cipher_due.size(), 0);

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
hdl/bpf_pkg.sv
hdl/bpf_locate.sv
hdl/bpf_lane.sv
hdl/bpf_square.sv
hdl/byte_playfair_digraph_cipher_unit.sv
hdl/bpf_checker.sv
sim/tb_byte_playfair_digraph_cipher_unit.sv
